/* design/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

/* design/tsct_pkg.sv */
// ----------------------------------------------------------------------------
// tsct_pkg
// Types and constants shared by the series sine,
// cosine and tangent block.
// ----------------------------------------------------------------------------
`default_nettype none
package tsct_pkg;

  localparam int unsigned DefMaxTerms = 12;
  localparam int unsigned DataW       = 32;
  localparam int unsigned TermW       = 4;
  localparam int unsigned AddrW       = 3;
  localparam logic [AddrW-1:0] RegTermCount = 3'd0;
  localparam logic [TermW-1:0] TermCountRst = 4'd6;

  // Magnitude register: Q.32 term up to 2^42
  localparam int unsigned MagW = 43;
  // Signed sum width
  localparam int unsigned SumW = 46;

  typedef struct packed {
    logic signed [DataW-1:0] sine;
    logic signed [DataW-1:0] cosine;
    logic signed [DataW-1:0] tangent;
    logic                    divide_by_zero;
    logic                    saturated;
  } result_t;

  // Divider handshake between the sequencer and the divide unit
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage
`default_nettype wire

/* design/tsct_if.sv */
// ----------------------------------------------------------------------------
// tsct_in_if / tsct_out_if
// Valid/ready channels carrying the angle and the result beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface tsct_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] angle;
  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface tsct_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sine;
  logic signed [31:0] cosine;
  logic signed [31:0] tangent;
  logic               divide_by_zero;
  logic               saturated;
  modport source (output valid, output sine, output cosine, output tangent,
                  output divide_by_zero, output saturated, input ready);
  modport sink   (input valid, input sine, input cosine, input tangent,
                  input divide_by_zero, input saturated, output ready);
endinterface
`default_nettype wire

/* design/taylor_sine_cosine_tangent_top.sv */
// ----------------------------------------------------------------------------
// taylor_sine_cosine_tangent_top
// Series sine and cosine of a Q3.28 angle, tangent by division.
// ----------------------------------------------------------------------------
// One angle beat is taken at a time, and the block is not ready while it works.
// Let n be the term count after clamping to 1..MaxTerms. The first term is
// only accumulated. Each of the other 2n-1 terms goes through the shared
// 43x16 multiplier for the high and low half of |x|, then through the shared
// 64-step serial divider to divide by k, and is then accumulated. Then come
// the rounding step, the tangent divide, the output step and the idle state.
// A zero cosine skips the tangent divide. The serial divider sets the rate.
// The result beat leaves from its own register, so the next angle is taken
// while a result waits. The sequencer stalls at its output step only while
// the previous result beat is still unread.
`default_nettype none
module taylor_sine_cosine_tangent_top
  import tsct_pkg::*;
#(
  parameter int unsigned MaxTerms = DefMaxTerms
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  tsct_in_if.sink                in_if,
  tsct_out_if.source             out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int unsigned KW = $clog2(2 * MaxTerms + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MULH  = 8'b0000_0010,
    S_MULL  = 8'b0000_0100,
    S_DIVK  = 8'b0000_1000,
    S_ACC   = 8'b0001_0000,
    S_ROUND = 8'b0010_0000,
    S_TAN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [TermW-1:0] term_count_q;
  logic [31:0]      mag_q;
  logic             neg_q;
  logic [MagW-1:0]  t_q;
  logic [59:0]      mid_q;
  logic signed [SumW-1:0] ssum_q, csum_q;
  logic [KW-1:0]    k_q, kmax_q;
  logic signed [DataW-1:0] s_q, c_q;
  logic             clip_q, dz_q, tneg_q;
  result_t          res_q;
  logic             out_valid_q;
  logic             res_we;

  // Shared multiplier: term magnitude by a 16-bit half of |x|
  logic [15:0] mul_b;
  logic [58:0] prod;
  assign mul_b = (state_q == S_MULH) ? 16'(mag_q >> 16) : mag_q[15:0];
  assign prod  = t_q * mul_b;

  // Divider shared for term/k and for the tangent
  logic            div_start;
  logic [63:0]     div_num;
  logic [31:0]     div_den;
  div_ctl_t        div_ctl;
  logic [63:0]     div_quo;

  tsct_div #(.NumW(64), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .ctl_o(div_ctl), .quo_o(div_quo)
  );

  // Configuration port
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr == (AddrW'(RegTermCount) << 2)) ? 32'(term_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) term_count_q <= TermCountRst;
    else if (cfg_we && paddr == (AddrW'(RegTermCount) << 2))
      term_count_q <= pwdata[TermW-1:0];
  end

  // Round a Q.32 sum to Q3.28 and saturate
  function automatic logic signed [DataW-1:0] rnd_sat(
    input logic signed [SumW-1:0] v, output logic clip);
    logic signed [SumW-1:0] r;
    r = (v + SumW'(8)) >>> 4;
    clip = 1'b0;
    if (r > SumW'(32'sh7fff_ffff)) begin
      clip = 1'b1; rnd_sat = 32'sh7fff_ffff;
    end else if (r < -SumW'(64'sh8000_0000)) begin
      clip = 1'b1; rnd_sat = 32'sh8000_0000;
    end else begin
      rnd_sat = r[DataW-1:0];
    end
  endfunction

  // Magnitude of a signed Q3.28 value
  function automatic logic [31:0] s_abs_r(input logic signed [31:0] v);
    s_abs_r = v[31] ? 32'(-v) : v;
  endfunction

  logic signed [DataW-1:0] s_r, c_r;
  logic cl_s, cl_c;
  logic signed [SumW-1:0] ssum_f;
  always_comb begin
    ssum_f = neg_q ? -ssum_q : ssum_q;
    s_r = rnd_sat(ssum_f, cl_s);
    c_r = rnd_sat(csum_q, cl_c);
  end

  logic [31:0] s_abs, c_abs;
  assign s_abs = s_q[31] ? 32'(-s_q) : s_q;
  assign c_abs = c_q[31] ? 32'(-c_q) : c_q;

  // Tangent quotient magnitude, then sign and saturation
  logic [63:0] tq;
  logic signed [DataW-1:0] tan_v;
  logic tan_clip;
  always_comb begin
    tq = div_quo;
    tan_clip = 1'b0;
    if (!tneg_q && tq > 64'h7fff_ffff) begin
      tan_v = 32'sh7fff_ffff; tan_clip = 1'b1;
    end else if (tneg_q && tq > 64'h8000_0000) begin
      tan_v = 32'sh8000_0000; tan_clip = 1'b1;
    end else begin
      tan_v = tneg_q ? 32'(-tq[31:0]) : tq[31:0];
    end
  end

  // Load the result register once the previous beat has left
  assign res_we = (state_q == S_OUT) && (!out_valid_q || out_if.ready);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = {21'd0, t_q};
    div_den   = 32'(k_q);
    unique case (state_q)
      S_IDLE:  if (in_if.valid) state_d = S_ACC;
      S_MULH:  state_d = S_MULL;
      S_MULL: begin
        div_start = 1'b1;
        div_num   = 64'(({mid_q, 16'd0} + 76'(prod)) >> 28);
        state_d   = S_DIVK;
      end
      S_DIVK:  if (div_ctl.done) state_d = S_ACC;
      S_ACC:   state_d = (k_q + 1'b1 == kmax_q) ? S_ROUND : S_MULH;
      S_ROUND: begin
        state_d = S_TAN;
        if (c_r != '0) begin
          div_start = 1'b1;
          div_num   = {s_abs_r(s_r), 32'd0} >> 16;
          div_den   = c_r[31] ? 32'(-c_r) : c_r;
        end
      end
      S_TAN:   if (dz_q || div_ctl.done) state_d = S_OUT;
      S_OUT:   if (res_we) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Result beat valid: set on load, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            out_valid_q <= 1'b0;
    else if (res_we)        out_valid_q <= 1'b1;
    else if (out_if.ready)  out_valid_q <= 1'b0;
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_if.valid) begin
        neg_q  <= in_if.angle[31];
        mag_q  <= in_if.angle[31] ? 32'(-in_if.angle) : in_if.angle;
        t_q    <= MagW'(64'd1 << 32);
        k_q    <= '0;
        ssum_q <= '0;
        csum_q <= '0;
        clip_q <= 1'b0;
        kmax_q <= (term_count_q == '0) ? KW'(2) :
                  (32'(term_count_q) > MaxTerms) ? KW'(2 * MaxTerms) :
                  KW'({term_count_q, 1'b0});
      end
      S_MULH:  mid_q <= 60'(prod);
      S_DIVK:  if (div_ctl.done) t_q <= div_quo[MagW-1:0];
      S_ACC: begin
        if (k_q[0]) ssum_q <= k_q[1] ? ssum_q - SumW'(t_q) : ssum_q + SumW'(t_q);
        else        csum_q <= k_q[1] ? csum_q - SumW'(t_q) : csum_q + SumW'(t_q);
        k_q <= k_q + 1'b1;
      end
      S_ROUND: begin
        s_q    <= s_r;
        c_q    <= c_r;
        clip_q <= cl_s | cl_c;
        dz_q   <= (c_r == '0);
        tneg_q <= s_r[31] ^ c_r[31];
      end
      S_OUT: if (res_we) begin
        res_q.sine           <= s_q;
        res_q.cosine         <= c_q;
        res_q.tangent        <= dz_q ? '0 : tan_v;
        res_q.divide_by_zero <= dz_q;
        res_q.saturated      <= clip_q | (!dz_q & tan_clip);
      end
      default: ;
    endcase
  end

  // Drive the handshakes and the result payload
  assign in_if.ready           = (state_q == S_IDLE);
  assign out_if.valid          = out_valid_q;
  assign out_if.sine           = res_q.sine;
  assign out_if.cosine         = res_q.cosine;
  assign out_if.tangent        = res_q.tangent;
  assign out_if.divide_by_zero = res_q.divide_by_zero;
  assign out_if.saturated      = res_q.saturated;

  logic unused_abs;
  assign unused_abs = ^{s_abs, c_abs, div_ctl.busy, div_ctl.start};

endmodule
`default_nettype wire

/* design/tsct_div.sv */
// ----------------------------------------------------------------------------
// tsct_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tsct_div
  import tsct_pkg::*;
#(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output div_ctl_t             ctl_o,
  output logic      [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  // Shift one numerator bit into the remainder and try the subtract
  always_comb begin
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    diff   = trial - {1'b0, den_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DenW]) begin
        rem_d = diff;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
  assign quo_o       = quo_q;

endmodule
`default_nettype wire

/* design/tsct_checker.sv */
// ----------------------------------------------------------------------------
// tsct_checker
// Port-level checks of the sine/cosine/tangent block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tsct_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] tangent,
  input wire logic        dz,
  input wire logic        pready
);
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, (out_valid && !out_ready) |=> out_valid, "beat dropped")
  `ASSERT_IMPL(a_tan_hold, clk_i, rst_ni, (out_valid && !out_ready) |=> $stable(tangent), "tan moved")
  `ASSERT_IMPL(a_dz_tan, clk_i, rst_ni, (out_valid && dz) |-> (tangent == 32'd0), "tan not zero")
  `ASSERT_IMPL(a_acc_busy, clk_i, rst_ni, (in_valid && in_ready) |=> !in_ready, "accepted twice")
  `ASSERT_ALWAYS(a_pready, clk_i, rst_ni, pready, "pready low")
endmodule

bind taylor_sine_cosine_tangent_top tsct_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .tangent(out_if.tangent),
  .dz(out_if.divide_by_zero), .pready(pready)
);
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the series sine, cosine and tangent block against a bit-exact
// predictor. Angles stream through the valid/ready input channel while the
// result channel is drained with random stalls. The term count is changed
// over the APB port between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import tsct_pkg::*;

  localparam int unsigned Period   = 12;
  localparam int unsigned MaxTermsTb = 12;
  localparam int unsigned DrainCycles = 1500;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  tsct_in_if  angle_ch ();
  tsct_out_if trig_ch ();

  taylor_sine_cosine_tangent_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (angle_ch),
    .out_if  (trig_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Testbench state
  logic [31:0]      angle_q[$];
  result_t          trig_expect_q[$];
  logic [TermW-1:0] terms_cfg;
  int               mismatch_cnt;
  int               send_gap;
  int               recv_gap;
  int               hold_off_cycles;
  bit               angle_taken;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #(Period / 2) clk_i = 1'b1;
    #(Period / 2) clk_i = 1'b0;
  end

  // Series predictor: Q.32 term recurrence, round half up to Q3.28
  function automatic result_t predict_trig(logic [31:0] raw, logic [TermW-1:0] cfg);
    result_t          r;
    bit               neg;
    longint unsigned  mag, t, mid;
    longint           term, ssum, csum, s, c, q;
    int unsigned      n;
    bit               clip;
    neg  = raw[31];
    mag  = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
    n    = cfg;
    if (n < 1) n = 1;
    if (n > MaxTermsTb) n = MaxTermsTb;
    t    = 64'd1 << 32;
    ssum = 0;
    csum = 0;
    clip = 1'b0;
    for (int unsigned k = 0; k < 2 * n; k++) begin
      if (k > 0) begin
        mid = t * (mag >> 16) + ((t * (mag & 64'hFFFF)) >> 16);
        t   = (mid >> 12) / k;
      end
      term = longint'(t);
      if (k[1]) term = -term;
      if (k[0]) ssum += term;
      else      csum += term;
    end
    if (neg) ssum = -ssum;
    s = (ssum + 8) >>> 4;
    c = (csum + 8) >>> 4;
    if (s > 64'sd2147483647) begin s = 64'sd2147483647; clip = 1'b1; end
    if (s < -64'sd2147483648) begin s = -64'sd2147483648; clip = 1'b1; end
    if (c > 64'sd2147483647) begin c = 64'sd2147483647; clip = 1'b1; end
    if (c < -64'sd2147483648) begin c = -64'sd2147483648; clip = 1'b1; end
    r.divide_by_zero = (c == 0);
    if (c == 0) begin
      q = 0;
    end else begin
      q = (s * 65536) / c;
      if (q > 64'sd2147483647) begin q = 64'sd2147483647; clip = 1'b1; end
      if (q < -64'sd2147483648) begin q = -64'sd2147483648; clip = 1'b1; end
    end
    r.sine      = s[31:0];
    r.cosine    = c[31:0];
    r.tangent   = q[31:0];
    r.saturated = clip;
    return r;
  endfunction

  // Mostly zero gaps, some short, a few long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(80, 20);
  endfunction

  // Angles: small ones in the useful range, full-range ones, edges
  function automatic logic [31:0] pick_angle();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 32'($signed($urandom_range(843314856, 0)) - 421657428);
    if (p < 90) return $urandom;
    return p[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // Input side: record accepted beats and predict them
  always @(posedge clk_i) begin
    angle_taken = 1'b0;
    if (rst_ni && angle_ch.valid && angle_ch.ready) begin
      trig_expect_q.push_back(predict_trig(angle_ch.angle, terms_cfg));
      angle_taken = 1'b1;
    end
  end

  // Angle driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_ch.valid <= 1'b0;
      angle_ch.angle <= '0;
      send_gap = 0;
    end else if (angle_ch.valid && !angle_taken) begin
      // hold the beat until accepted
    end else if (send_gap > 0) begin
      send_gap--;
      angle_ch.valid <= 1'b0;
    end else if (angle_q.size() > 0) begin
      angle_ch.angle <= angle_q.pop_front();
      angle_ch.valid <= 1'b1;
      send_gap = pick_gap();
    end else begin
      angle_ch.valid <= 1'b0;
    end
  end

  // Result ready driver with random stalls and a forced long hold-off
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ch.ready <= 1'b0;
      recv_gap = 0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      trig_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      trig_ch.ready <= 1'b0;
    end else begin
      trig_ch.ready <= 1'b1;
      recv_gap = pick_gap();
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && trig_ch.valid && trig_ch.ready) begin
      if (trig_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: unexpected result beat sin=%h cos=%h", trig_ch.sine,
                   trig_ch.cosine);
      end else begin
        want = trig_expect_q.pop_front();
        if (trig_ch.sine !== want.sine || trig_ch.cosine !== want.cosine ||
            trig_ch.tangent !== want.tangent ||
            trig_ch.divide_by_zero !== want.divide_by_zero ||
            trig_ch.saturated !== want.saturated) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: exp sin=%h cos=%h tan=%h dz=%b sat=%b, got sin=%h cos=%h tan=%h dz=%b sat=%b",
                     want.sine, want.cosine, want.tangent, want.divide_by_zero,
                     want.saturated, trig_ch.sine, trig_ch.cosine, trig_ch.tangent,
                     trig_ch.divide_by_zero, trig_ch.saturated);
        end
      end
    end
  end

  // APB register write: setup then access
  task automatic write_reg(logic [AddrW-1:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until all angles are taken and all results are back
  task automatic drain();
    while (angle_q.size() > 0 || angle_ch.valid || trig_expect_q.size() > 0)
      @(posedge clk_i);
  endtask

  // Change the term count on an idle block
  task automatic set_terms(logic [TermW-1:0] cnt);
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(RegTermCount, {28'd0, cnt});
    terms_cfg = cnt;
  endtask

  // Stimulus
  initial begin
    logic [TermW-1:0] cnt;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatch_cnt = 0;
    hold_off_cycles = 0;
    terms_cfg = TermCountRst;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset setting, field extremes, near quarter turn
    angle_q.push_back(32'h0000_0000);
    angle_q.push_back(32'h7FFF_FFFF);
    angle_q.push_back(32'h8000_0000);
    angle_q.push_back(32'h0000_0001);
    angle_q.push_back(32'hFFFF_FFFF);
    angle_q.push_back(32'd421657428);
    angle_q.push_back(-32'sd421657428);
    angle_q.push_back(32'h1000_0000);
    angle_q.push_back(32'hAAAA_AAAA);
    angle_q.push_back(32'h5555_5555);

    // zero terms behaves as one, above maximum clamps
    set_terms(4'd0);
    angle_q.push_back(32'h8000_0000);
    angle_q.push_back(32'h1234_5678);
    set_terms(4'd15);
    angle_q.push_back(32'h7FFF_FFFF);
    angle_q.push_back(32'd421657428);
    set_terms(4'd12);
    angle_q.push_back(32'h8000_0000);
    angle_q.push_back(32'h0000_0000);
    angle_q.push_back(32'd843314856);
    set_terms(4'd1);
    angle_q.push_back(32'hFFFF_FFFF);
    angle_q.push_back(32'h0000_0001);

    // long receiver hold-off while angles keep coming
    set_terms(4'd2);
    for (int i = 0; i < 20; i++) angle_q.push_back(pick_angle());
    hold_off_cycles = 3000;

    // random phases, small term counts dominate
    for (int ph = 0; ph < 10; ph++) begin
      cnt = ($urandom_range(9) < 7) ? 4'($urandom_range(4, 1)) : 4'($urandom_range(15, 0));
      if (ph == 9) cnt = 4'd12;
      set_terms(cnt);
      for (int i = 0; i < ((ph == 9) ? 10 : 37); i++) angle_q.push_back(pick_angle());
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(60_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* taylor_sine_cosine_tangent_top.f */
+incdir+design
design/tsct_pkg.sv
design/tsct_if.sv
design/tsct_div.sv
design/taylor_sine_cosine_tangent_top.sv
design/tsct_checker.sv
verif/tb.sv
